[hdl/assert_macros.svh]
// Assertion macros for the scheduler RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under clock and active-low reset.
`define ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under clock and active-low reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/sjf_pkg.sv]
// Shared types and constants for the SJF scheduler.
// Used by sjf_ctrl, sjf_datapath and the top level; no dependencies.
package sjf_pkg;

	localparam int MAX_JOBS_DEF = 32;
	localparam int ID_W   = 8;
	localparam int TIME_W = 16;
	localparam int TICK_W = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_END,
		ST_CALC,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic calc;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
		logic out_free;
		logic set_last;
	} status_t;

endpackage

[hdl/sjf_ctrl.sv]
// Controller FSM of the SJF scheduler: load, scan, calc, emit sequencing.
// Depends on sjf_pkg for the state enum and command/status structs.
module sjf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              last_job,
	input  sjf_pkg::status_t  st,
	output logic              in_ready,
	output sjf_pkg::cmd_t     cmd
);
	import sjf_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (last_job) state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (st.scan_last) state_d = ST_SCAN_END;
			end
			ST_SCAN_END: begin
				state_d = ST_CALC;
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d  = st.set_last ? ST_IDLE : ST_SCAN;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

[hdl/sjf_datapath.sv]
// Datapath of the SJF scheduler: job memory, selection scan, timing math, output register.
// Depends on sjf_pkg and assert_macros.svh; driven by sjf_ctrl commands.
`include "assert_macros.svh"
module sjf_datapath #(
	parameter int MAX_JOBS = sjf_pkg::MAX_JOBS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sjf_pkg::cmd_t                cmd,
	output sjf_pkg::status_t             st,
	input  logic [sjf_pkg::ID_W-1:0]     job_id,
	input  logic [sjf_pkg::TIME_W-1:0]   arrival_time,
	input  logic [sjf_pkg::TIME_W-1:0]   burst_time,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic [sjf_pkg::ID_W-1:0]     served_id,
	output logic [sjf_pkg::TICK_W-1:0]   start_tick,
	output logic [sjf_pkg::TICK_W-1:0]   finish_tick,
	output logic [sjf_pkg::TICK_W-1:0]   wait_ticks,
	output logic [sjf_pkg::TICK_W-1:0]   turnaround_ticks,
	output logic [sjf_pkg::TICK_W-1:0]   total_wait,
	output logic [sjf_pkg::TICK_W-1:0]   total_turnaround,
	output logic                         last_result
);
	import sjf_pkg::*;

	localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CW = $clog2(MAX_JOBS + 1);
	localparam int EW = ID_W + 2 * TIME_W;

	logic [EW-1:0]     mem [MAX_JOBS];
	logic [EW-1:0]     rd_data_s1;
	logic              rd_vld_s1, rd_first_s1, rd_done_s1;
	logic [IW-1:0]     rd_idx_s1;

	logic [CW-1:0]     count_q, served_q;
	logic [IW-1:0]     scan_idx_q;
	logic [MAX_JOBS-1:0] done_q;
	logic [TICK_W-1:0] clock_q, wait_sum_q, tat_sum_q;

	logic              valid_arr_q, valid_pend_q;
	logic [TIME_W-1:0] ba_burst_q, ba_arr_q, bp_burst_q, bp_arr_q;
	logic [ID_W-1:0]   ba_id_q, bp_id_q;
	logic [IW-1:0]     ba_idx_q, bp_idx_q;

	logic [TICK_W-1:0] start_q, finish_q, wait_q, tat_q;
	logic [ID_W-1:0]   pid_q;
	logic [IW-1:0]     pidx_q;

	logic              out_valid_q, last_q;
	logic [ID_W-1:0]   out_id_q;
	logic [TICK_W-1:0] out_start_q, out_finish_q, out_wait_q, out_tat_q;
	logic [TICK_W-1:0] out_twait_q, out_ttat_q;

	logic [ID_W-1:0]   rd_id;
	logic [TIME_W-1:0] rd_arr, rd_burst;
	logic              arrived, base_va, base_vp, take_arr, take_pend;
	logic              wr_en;
	logic [TIME_W-1:0] sel_arr, sel_burst;
	logic [TICK_W-1:0] sel_start;
	logic [TICK_W:0]   wsum, tsum;
	logic [TICK_W-1:0] wait_next, tat_next;

	assign wr_en = cmd.load && (count_q < CW'(MAX_JOBS));
	assign {rd_id, rd_arr, rd_burst} = rd_data_s1;

	assign st.scan_last = (CW'(scan_idx_q) == count_q - CW'(1));
	assign st.out_free  = !out_valid_q || out_ready;
	assign st.set_last  = ((served_q + CW'(1)) == count_q);

	// candidate tracking: best arrived job and earliest pending job
	always_comb begin
		arrived   = ({{(TICK_W-TIME_W){1'b0}}, rd_arr} <= clock_q);
		base_va   = valid_arr_q && !rd_first_s1;
		base_vp   = valid_pend_q && !rd_first_s1;
		take_arr  = rd_vld_s1 && !rd_done_s1 && arrived &&
			(!base_va || (rd_burst < ba_burst_q) ||
			 ((rd_burst == ba_burst_q) && (rd_arr < ba_arr_q)));
		take_pend = rd_vld_s1 && !rd_done_s1 && !arrived &&
			(!base_vp || (rd_arr < bp_arr_q) ||
			 ((rd_arr == bp_arr_q) && (rd_burst < bp_burst_q)));
	end

	always_comb begin
		sel_arr   = valid_arr_q ? ba_arr_q : bp_arr_q;
		sel_burst = valid_arr_q ? ba_burst_q : bp_burst_q;
		sel_start = valid_arr_q ? clock_q : {{(TICK_W-TIME_W){1'b0}}, bp_arr_q};
		wsum      = {1'b0, wait_sum_q} + {1'b0, wait_q};
		tsum      = {1'b0, tat_sum_q} + {1'b0, tat_q};
		wait_next = wsum[TICK_W] ? '1 : wsum[TICK_W-1:0];
		tat_next  = tsum[TICK_W] ? '1 : tsum[TICK_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[count_q[IW-1:0]] <= {job_id, arrival_time, burst_time};
		rd_data_s1 <= mem[scan_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			served_q     <= '0;
			scan_idx_q   <= '0;
			done_q       <= '0;
			clock_q      <= '0;
			wait_sum_q   <= '0;
			tat_sum_q    <= '0;
			rd_vld_s1    <= 1'b0;
			valid_arr_q  <= 1'b0;
			valid_pend_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan;
			if (wr_en) count_q <= count_q + CW'(1);
			if (cmd.scan) scan_idx_q <= st.scan_last ? '0 : scan_idx_q + IW'(1);
			if (rd_vld_s1) begin
				valid_arr_q  <= base_va || take_arr;
				valid_pend_q <= base_vp || take_pend;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				if (st.set_last) begin
					count_q    <= '0;
					served_q   <= '0;
					done_q     <= '0;
					clock_q    <= '0;
					wait_sum_q <= '0;
					tat_sum_q  <= '0;
				end else begin
					served_q       <= served_q + CW'(1);
					done_q[pidx_q] <= 1'b1;
					clock_q        <= finish_q;
					wait_sum_q     <= wait_next;
					tat_sum_q      <= tat_next;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_first_s1 <= (scan_idx_q == '0);
		rd_done_s1  <= done_q[scan_idx_q];
		rd_idx_s1   <= scan_idx_q;
		if (take_arr) begin
			ba_burst_q <= rd_burst;
			ba_arr_q   <= rd_arr;
			ba_id_q    <= rd_id;
			ba_idx_q   <= rd_idx_s1;
		end
		if (take_pend) begin
			bp_burst_q <= rd_burst;
			bp_arr_q   <= rd_arr;
			bp_id_q    <= rd_id;
			bp_idx_q   <= rd_idx_s1;
		end
		if (cmd.calc) begin
			start_q  <= sel_start;
			finish_q <= sel_start + {{(TICK_W-TIME_W){1'b0}}, sel_burst};
			wait_q   <= sel_start - {{(TICK_W-TIME_W){1'b0}}, sel_arr};
			tat_q    <= sel_start + {{(TICK_W-TIME_W){1'b0}}, sel_burst}
				- {{(TICK_W-TIME_W){1'b0}}, sel_arr};
			pid_q    <= valid_arr_q ? ba_id_q : bp_id_q;
			pidx_q   <= valid_arr_q ? ba_idx_q : bp_idx_q;
		end
		if (cmd.emit) begin
			out_id_q     <= pid_q;
			out_start_q  <= start_q;
			out_finish_q <= finish_q;
			out_wait_q   <= wait_q;
			out_tat_q    <= tat_q;
			out_twait_q  <= wait_next;
			out_ttat_q   <= tat_next;
			last_q       <= st.set_last;
		end
	end

	assign out_valid        = out_valid_q;
	assign served_id        = out_id_q;
	assign start_tick       = out_start_q;
	assign finish_tick      = out_finish_q;
	assign wait_ticks       = out_wait_q;
	assign turnaround_ticks = out_tat_q;
	assign total_wait       = out_twait_q;
	assign total_turnaround = out_ttat_q;
	assign last_result      = last_q;

	`ASSERT_NOW(a_emit_free, clk, arst_n, cmd.emit, !out_valid_q || out_ready, "emit while output held")
	`ASSERT_NOW(a_calc_cand, clk, arst_n, cmd.calc, valid_arr_q || valid_pend_q, "no candidate at calc")
	`ASSERT_NOW(a_pick_undone, clk, arst_n, cmd.emit, !done_q[pidx_q], "picked job already served")
	`ASSERT_NEXT(a_end_clear, clk, arst_n, cmd.emit && st.set_last, count_q == '0 && done_q == '0, "set not cleared after last result")

endmodule

[hdl/sjf_nonpreemptive_scheduler.sv]
// Non-preemptive SJF scheduler: when idle, it loads one job request per cycle.
// After the last job, each result comes from a scan of the N stored jobs through
// the single read port of the job memory, then a drain, calc and emit step.
// Reset clears job count, served flags, clock and totals; job memory is not cleared.
module sjf_nonpreemptive_scheduler #(
	parameter int MAX_JOBS = sjf_pkg::MAX_JOBS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [sjf_pkg::ID_W-1:0]     job_id,
	input  logic [sjf_pkg::TIME_W-1:0]   arrival_time,
	input  logic [sjf_pkg::TIME_W-1:0]   burst_time,
	input  logic                         last_job,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [sjf_pkg::ID_W-1:0]     served_id,
	output logic [sjf_pkg::TICK_W-1:0]   start_tick,
	output logic [sjf_pkg::TICK_W-1:0]   finish_tick,
	output logic [sjf_pkg::TICK_W-1:0]   wait_ticks,
	output logic [sjf_pkg::TICK_W-1:0]   turnaround_ticks,
	output logic [sjf_pkg::TICK_W-1:0]   total_wait,
	output logic [sjf_pkg::TICK_W-1:0]   total_turnaround,
	output logic                         last_result
);
	import sjf_pkg::*;

	cmd_t    cmd;
	status_t st;

	sjf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.last_job (last_job),
		.st       (st),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	sjf_datapath #(
		.MAX_JOBS (MAX_JOBS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.st               (st),
		.job_id           (job_id),
		.arrival_time     (arrival_time),
		.burst_time       (burst_time),
		.out_ready        (out_ready),
		.out_valid        (out_valid),
		.served_id        (served_id),
		.start_tick       (start_tick),
		.finish_tick      (finish_tick),
		.wait_ticks       (wait_ticks),
		.turnaround_ticks (turnaround_ticks),
		.total_wait       (total_wait),
		.total_turnaround (total_turnaround),
		.last_result      (last_result)
	);

endmodule

[sim/tb_sjf_nonpreemptive_scheduler.sv]
// Testbench for sjf_nonpreemptive_scheduler: loads job sets, predicts the SJF schedule
// and checks every result request field by field. Depends on sjf_pkg and the scheduler RTL.
module tb_sjf_nonpreemptive_scheduler;
	timeunit 1ns;
	timeprecision 1ps;

	import sjf_pkg::*;

	localparam int MAX_JOBS   = MAX_JOBS_DEF;
	localparam int IDLE_LIMIT = 3000;
	localparam int ITEM_GOAL  = 280;

	typedef struct {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] arrival;
		logic [TIME_W-1:0] burst;
	} job_t;

	typedef struct {
		logic [ID_W-1:0]   id;
		logic [TICK_W-1:0] start;
		logic [TICK_W-1:0] finish;
		logic [TICK_W-1:0] wait_t;
		logic [TICK_W-1:0] tat;
		logic [TICK_W-1:0] wait_total;
		logic [TICK_W-1:0] tat_total;
		logic              last;
	} slot_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [ID_W-1:0]   job_id;
	logic [TIME_W-1:0] arrival_time;
	logic [TIME_W-1:0] burst_time;
	logic              last_job;
	logic              out_valid;
	logic              out_ready;
	logic [ID_W-1:0]   served_id;
	logic [TICK_W-1:0] start_tick;
	logic [TICK_W-1:0] finish_tick;
	logic [TICK_W-1:0] wait_ticks;
	logic [TICK_W-1:0] turnaround_ticks;
	logic [TICK_W-1:0] total_wait;
	logic [TICK_W-1:0] total_turnaround;
	logic              last_result;

	job_t  loaded_jobs[$];
	slot_t schedule_q[$];
	int    errors      = 0;
	int    jobs_sent   = 0;
	int    idle_cycles = 0;
	int    stall_left  = 0;
	bit    steady_in   = 0;
	bit    steady_out  = 0;

	sjf_nonpreemptive_scheduler #(.MAX_JOBS(MAX_JOBS)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.job_id(job_id), .arrival_time(arrival_time), .burst_time(burst_time),
		.last_job(last_job),
		.out_valid(out_valid), .out_ready(out_ready),
		.served_id(served_id), .start_tick(start_tick), .finish_tick(finish_tick),
		.wait_ticks(wait_ticks), .turnaround_ticks(turnaround_ticks),
		.total_wait(total_wait), .total_turnaround(total_turnaround),
		.last_result(last_result)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [TICK_W-1:0] sat_sum(logic [TICK_W-1:0] a, logic [TICK_W-1:0] b);
		logic [TICK_W:0] s;
		s = a + b;
		return s[TICK_W] ? '1 : s[TICK_W-1:0];
	endfunction

	// shorter burst first, then earlier arrival, then load order
	function automatic bit runs_first(int a, int b);
		if (loaded_jobs[a].burst != loaded_jobs[b].burst)
			return loaded_jobs[a].burst < loaded_jobs[b].burst;
		if (loaded_jobs[a].arrival != loaded_jobs[b].arrival)
			return loaded_jobs[a].arrival < loaded_jobs[b].arrival;
		return a < b;
	endfunction

	function automatic void build_schedule();
		bit                served[MAX_JOBS];
		logic [TICK_W-1:0] now;
		logic [TICK_W-1:0] earliest;
		logic [TICK_W-1:0] wsum;
		logic [TICK_W-1:0] tsum;
		int                pick;
		slot_t             s;
		now  = '0;
		wsum = '0;
		tsum = '0;
		foreach (served[k])
			served[k] = 1'b0;
		for (int n = 0; n < loaded_jobs.size(); n++) begin
			earliest = '1;
			for (int k = 0; k < loaded_jobs.size(); k++)
				if (!served[k] && loaded_jobs[k].arrival < earliest)
					earliest = loaded_jobs[k].arrival;
			if (earliest > now)
				now = earliest;
			pick = -1;
			for (int k = 0; k < loaded_jobs.size(); k++) begin
				if (served[k] || loaded_jobs[k].arrival > now)
					continue;
				if (pick < 0 || runs_first(k, pick))
					pick = k;
			end
			s.id         = loaded_jobs[pick].id;
			s.start      = now;
			s.finish     = now + loaded_jobs[pick].burst;
			s.wait_t     = now - loaded_jobs[pick].arrival;
			s.tat        = s.finish - loaded_jobs[pick].arrival;
			wsum         = sat_sum(wsum, s.wait_t);
			tsum         = sat_sum(tsum, s.tat);
			s.wait_total = wsum;
			s.tat_total  = tsum;
			s.last       = (n == loaded_jobs.size() - 1);
			now          = s.finish;
			served[pick] = 1'b1;
			schedule_q.push_back(s);
		end
		loaded_jobs.delete();
	endfunction

	function automatic void load_job(job_t j, bit last);
		if (loaded_jobs.size() < MAX_JOBS)
			loaded_jobs.push_back(j);
		if (last)
			build_schedule();
	endfunction

	task automatic send_job(logic [ID_W-1:0] id, logic [TIME_W-1:0] arr,
			logic [TIME_W-1:0] burst, bit last);
		int   gap;
		job_t j;
		if ($urandom_range(0, 99) == 0)
			steady_in = !steady_in;
		gap = (steady_in || $urandom_range(0, 1)) ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		job_id       <= id;
		arrival_time <= arr;
		burst_time   <= burst;
		last_job     <= last;
		do
			@(posedge clk);
		while (!in_ready);
		j.id      = id;
		j.arrival = arr;
		j.burst   = burst;
		load_job(j, last);
		jobs_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (schedule_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_extremes();
		send_job(8'hFF, 16'hFFFF, 16'hFFFF, 1'b1);
		send_job(8'h00, 16'h0000, 16'h0000, 1'b1);
		send_job(8'h5A, 16'h0000, 16'hFFFF, 1'b0);
		send_job(8'hA5, 16'hFFFF, 16'h0000, 1'b1);
	endtask

	task automatic test_tie_break();
		send_job(8'd1, 16'd2, 16'd4, 1'b0);
		send_job(8'd2, 16'd0, 16'd4, 1'b0);
		send_job(8'd3, 16'd0, 16'd4, 1'b0);
		send_job(8'd4, 16'd0, 16'd9, 1'b0);
		send_job(8'd5, 16'd1, 16'd1, 1'b1);
	endtask

	task automatic test_idle_clock();
		send_job(8'd10, 16'd100, 16'd5, 1'b0);
		send_job(8'd11, 16'd300, 16'd2, 1'b0);
		send_job(8'd12, 16'd50, 16'd7, 1'b1);
	endtask

	task automatic test_zero_burst();
		send_job(8'd20, 16'd3, 16'd0, 1'b0);
		send_job(8'd21, 16'd3, 16'd0, 1'b0);
		send_job(8'd22, 16'd0, 16'd2, 1'b0);
		send_job(8'd23, 16'd2, 16'd0, 1'b1);
	endtask

	// jobs past the store size are dropped, the last one still starts scheduling
	task automatic test_store_full();
		for (int i = 0; i < MAX_JOBS + 2; i++)
			send_job(ID_W'($urandom_range(0, 255)), TIME_W'($urandom_range(0, 63)),
				TIME_W'($urandom_range(0, 15)), i == MAX_JOBS + 1);
	endtask

	task automatic random_job_set(int n);
		logic [TIME_W-1:0] arr_span;
		logic [TIME_W-1:0] burst_span;
		case ($urandom_range(0, 2))
			0: arr_span = 16'd15;
			1: arr_span = 16'd255;
			default: arr_span = 16'hFFFF;
		endcase
		case ($urandom_range(0, 3))
			0: burst_span = 16'd0;
			1: burst_span = 16'd7;
			2: burst_span = 16'd300;
			default: burst_span = 16'hFFFF;
		endcase
		for (int i = 0; i < n; i++)
			send_job(ID_W'($urandom_range(0, 255)), TIME_W'($urandom_range(0, arr_span)),
				TIME_W'($urandom_range(0, burst_span)), i == n - 1);
	endtask

	task automatic test_random_sets();
		int r;
		int n;
		while (jobs_sent < ITEM_GOAL) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				n = $urandom_range(1, 8);
			else if (r < 92)
				n = $urandom_range(9, MAX_JOBS - 1);
			else if (r < 97)
				n = MAX_JOBS;
			else
				n = MAX_JOBS + $urandom_range(1, 3);
			random_job_set(n);
			if ($urandom_range(0, 9) == 0)
				drain_results();
		end
	endtask

	always @(posedge clk) begin
		if ($urandom_range(0, 299) == 0)
			steady_out = !steady_out;
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (!steady_out && $urandom_range(0, 3) == 0) begin
			stall_left = pick_gap() - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	function automatic void check_field(string name, logic [TICK_W-1:0] want,
			logic [TICK_W-1:0] got);
		if (got !== want) begin
			$display("%0t ERROR %s expected %0d actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		slot_t want;
		if (arst_n && out_valid && out_ready) begin
			if (schedule_q.size() == 0) begin
				$display("%0t ERROR unexpected result request expected none actual id %0d",
					$time, served_id);
				errors++;
			end else begin
				want = schedule_q.pop_front();
				check_field("served_id", want.id, served_id);
				check_field("start_tick", want.start, start_tick);
				check_field("finish_tick", want.finish, finish_tick);
				check_field("wait_ticks", want.wait_t, wait_ticks);
				check_field("turnaround_ticks", want.tat, turnaround_ticks);
				check_field("total_wait", want.wait_total, total_wait);
				check_field("total_turnaround", want.tat_total, total_turnaround);
				check_field("last_result", want.last, last_result);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t ERROR watchdog: no request accepted for %0d cycles", $time, IDLE_LIMIT);
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		job_id       = '0;
		arrival_time = '0;
		burst_time   = '0;
		last_job     = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_tie_break();
		test_idle_clock();
		test_zero_burst();
		drain_results();
		test_store_full();
		test_random_sets();
		drain_results();
		repeat (50) @(posedge clk);
		if (errors == 0 && schedule_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
